>>> rtl/core/assert_macros.svh
// assertion macros for the translation core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/core/bmft_pkg.sv
// package: constants, types and command codes for the translation core
package bmft_pkg;
    localparam int unsigned BLOCKS_DEF = 256;
    localparam int unsigned PPB_DEF    = 16;
    localparam int unsigned LP_W       = 12;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_PROGRAM = 2'd1,
        CMD_ERASE   = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_NO_FREE  = 2'd2
    } t_status;

    // datapath step selected by the controller
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOOKUP    = 4'd1,
        OP_SCAN      = 4'd2,
        OP_EMIT_READ = 4'd3,
        OP_EMIT_ERR  = 4'd4,
        OP_NEW_MAP   = 4'd5,
        OP_DIRECT    = 4'd6,
        OP_MOVE      = 4'd7,
        OP_ERASE     = 4'd8,
        OP_CLEAR     = 4'd9
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status err;
        logic    rd_half;
        logic    first;
    } t_ctl;

    typedef struct packed {
        logic mapped;
        logic page_wr;
        logic scan_done;
        logic have_free;
        logic move_last;
        logic at_off;
        logic clear_done;
    } t_sts;
endpackage

>>> rtl/core/bmft_datapath.sv
// datapath: map, page bits, block bits, free scan and command output
`include "assert_macros.svh"
module bmft_datapath #(
    parameter int unsigned BLOCKS = bmft_pkg::BLOCKS_DEF,
    parameter int unsigned PPB    = bmft_pkg::PPB_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [bmft_pkg::LP_W-1:0]   i_logical_page,
    input  bmft_pkg::t_ctl              i_ctl,
    output bmft_pkg::t_sts              o_sts,
    output logic                        o_valid,
    output logic [1:0]                  o_command,
    output logic [bmft_pkg::LP_W-1:0]   o_flash_page,
    output logic                        o_from_host,
    output logic [1:0]                  o_status,
    output logic                        o_last
);
    import bmft_pkg::*;

    localparam int unsigned BW  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int unsigned OW  = (PPB > 1) ? $clog2(PPB) : 1;
    localparam int unsigned PGS = BLOCKS * PPB;
    localparam int unsigned PW  = $clog2(PGS);
    localparam int unsigned CW  = BW + 1;
    localparam int unsigned QSH = LP_W + OW;
    localparam longint unsigned QMUL = ((64'd1 << QSH) + PPB - 1) / PPB;
    localparam int unsigned BSH = LP_W + BW;
    localparam longint unsigned BMUL = ((64'd1 << BSH) + BLOCKS - 1) / BLOCKS;

    logic [BW:0]   r_map   [BLOCKS];
    logic          r_pw    [PGS];
    logic [BLOCKS-1:0] r_used;

    logic [BW-1:0] r_lb, n_lb;
    logic [OW-1:0] r_off, n_off;
    logic [BW-1:0] r_ob, r_nb, r_ptr, r_scan;
    logic [CW-1:0] r_cnt;
    logic          r_mapped, r_pwr, r_found;
    logic [OW-1:0] r_i;
    logic [BW-1:0] r_clr;
    logic          r_clr_done;
    logic [BW:0]   r_rd_map;
    logic          r_rd_pw;

    logic [LP_W-1:0] w_blk, w_bq;
    logic [31:0]     w_prod_q, w_prod_b, w_rem_b, w_rem_p;

    logic [1:0]      n_command;
    logic [LP_W-1:0] n_flash_page;
    logic            n_from_host;
    logic [1:0]      n_status;
    logic            n_last;

    // division by constants through reciprocal multiplication
    always_comb begin
        w_prod_q = 32'(i_logical_page) * 32'(QMUL);
        w_blk    = LP_W'(w_prod_q >> QSH);
        w_prod_b = 32'(w_blk) * 32'(BMUL);
        w_bq     = LP_W'(w_prod_b >> BSH);
        w_rem_b  = 32'(w_blk) - 32'(w_bq) * BLOCKS;
        w_rem_p  = 32'(i_logical_page) - 32'(w_blk) * PPB;
        n_lb     = BW'(w_rem_b);
        n_off    = OW'(w_rem_p);
    end

    function automatic logic [LP_W-1:0] f_page(input logic [BW-1:0] b, input logic [OW-1:0] o);
        logic [PW+1:0] t;
        t = (PW+2)'(b) * (PW+2)'(PPB) + (PW+2)'(o);
        return LP_W'(t);
    endfunction

    function automatic logic [PW-1:0] f_idx(input logic [BW-1:0] b, input logic [OW-1:0] o);
        logic [PW+1:0] t;
        t = (PW+2)'(b) * (PW+2)'(PPB) + (PW+2)'(o);
        return PW'(t);
    endfunction

    logic w_scan_wrap;
    always_comb begin
        w_scan_wrap = (32'(r_scan) == BLOCKS - 1);
    end

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        r_rd_map <= r_map[r_lb];
        r_rd_pw  <= r_pw[f_idx(r_rd_map[BW-1:0], r_off)];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lb  <= n_lb;
            r_off <= n_off;
        end
        if (i_ctl.op == OP_LOOKUP) begin
            r_mapped <= r_rd_map[BW];
            r_ob     <= r_rd_map[BW-1:0];
        end
        if (i_ctl.op == OP_SCAN && i_ctl.first) begin
            r_pwr <= r_rd_pw;
        end
        if (i_ctl.op == OP_CLEAR) begin
            r_map[r_clr] <= '0;
            r_pw[f_idx(r_clr, r_i)] <= 1'b0;
        end else if (i_ctl.op == OP_NEW_MAP) begin
            r_map[r_lb] <= {1'b1, r_nb};
            r_pw[f_idx(r_nb, r_off)] <= 1'b1;
        end else if (i_ctl.op == OP_DIRECT) begin
            r_pw[f_idx(r_ob, r_off)] <= 1'b1;
        end else if (i_ctl.op == OP_MOVE && !i_ctl.rd_half) begin
            r_pw[f_idx(r_nb, r_i)] <= 1'b1;
        end else if (i_ctl.op == OP_ERASE) begin
            r_map[r_lb] <= {1'b1, r_nb};
            r_pw[f_idx(r_ob, r_i)] <= 1'b0;
        end
    end

    // clear pass, free scan, used bits; r_i walks pages in clear/move/erase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_ptr      <= '0;
            r_scan     <= '0;
            r_cnt      <= '0;
            r_found    <= 1'b0;
            r_i        <= '0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_nb       <= '0;
        end else begin
            unique case (i_ctl.op)
                OP_CLEAR: begin
                    if (32'(r_i) == PPB - 1) begin
                        r_i <= '0;
                        if (32'(r_clr) == BLOCKS - 1) r_clr_done <= 1'b1;
                        else r_clr <= r_clr + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                OP_SCAN: begin
                    if (i_ctl.first) begin
                        r_scan  <= r_ptr;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                    end else if (!r_found && 32'(r_cnt) < BLOCKS) begin
                        if (!r_used[r_scan]) begin
                            r_found <= 1'b1;
                            r_nb    <= r_scan;
                        end else begin
                            r_scan <= w_scan_wrap ? '0 : r_scan + 1'b1;
                            r_cnt  <= r_cnt + 1'b1;
                        end
                    end
                end
                OP_NEW_MAP: begin
                    r_used[r_nb] <= 1'b1;
                    r_ptr        <= r_nb;
                end
                OP_DIRECT: begin
                    if (r_found) r_ptr <= r_nb;
                end
                OP_MOVE: begin
                    if (i_ctl.first) begin
                        r_i          <= '0;
                        r_ptr        <= r_nb;
                        r_used[r_nb] <= 1'b1;
                    end else if (!i_ctl.rd_half) begin
                        r_i <= (32'(r_i) == PPB - 1) ? '0 : r_i + 1'b1;
                    end
                end
                OP_ERASE: begin
                    if (i_ctl.first) begin
                        r_used[r_ob] <= 1'b0;
                    end
                    r_i <= (32'(r_i) == PPB - 1) ? '0 : r_i + 1'b1;
                end
                default: begin
                    if (i_ctl.op == OP_EMIT_ERR && r_found) r_ptr <= r_nb;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                OP_EMIT_READ, OP_EMIT_ERR, OP_NEW_MAP, OP_DIRECT: o_valid <= 1'b1;
                OP_MOVE: o_valid <= !i_ctl.first;
                OP_ERASE: o_valid <= i_ctl.first;
                default: o_valid <= 1'b0;
            endcase
        end
    end

    always_comb begin
        n_from_host  = 1'b0;
        n_status     = ST_OK;
        n_last       = 1'b1;
        n_flash_page = '0;
        n_command    = CMD_NOP;
        unique case (i_ctl.op)
            OP_EMIT_READ: begin
                n_command    = CMD_READ;
                n_flash_page = f_page(r_ob, r_off);
            end
            OP_EMIT_ERR: begin
                n_status = i_ctl.err;
            end
            OP_NEW_MAP: begin
                n_command    = CMD_PROGRAM;
                n_flash_page = f_page(r_nb, r_off);
                n_from_host  = 1'b1;
            end
            OP_DIRECT: begin
                n_command    = CMD_PROGRAM;
                n_flash_page = f_page(r_ob, r_off);
                n_from_host  = 1'b1;
            end
            OP_MOVE: begin
                n_last = 1'b0;
                if (i_ctl.rd_half) begin
                    n_command    = CMD_READ;
                    n_flash_page = f_page(r_ob, r_i);
                end else begin
                    n_command    = CMD_PROGRAM;
                    n_flash_page = f_page(r_nb, r_i);
                    n_from_host  = (r_i == r_off);
                end
            end
            OP_ERASE: begin
                n_command    = CMD_ERASE;
                n_flash_page = f_page(r_ob, r_off);
            end
            default: n_command = CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_command    <= n_command;
        o_flash_page <= n_flash_page;
        o_from_host  <= n_from_host;
        o_status     <= n_status;
        o_last       <= n_last;
    end

    always_comb begin
        o_sts.mapped     = r_mapped;
        o_sts.page_wr    = r_pwr;
        o_sts.scan_done  = r_found || (32'(r_cnt) >= BLOCKS);
        o_sts.have_free  = r_found;
        o_sts.move_last  = (32'(r_i) == PPB - 1);
        o_sts.at_off     = (r_i == r_off);
        o_sts.clear_done = r_clr_done;
    end

    `ASSERT_IMPL(a_found_free, i_clk, i_rst_n, i_ctl.op == OP_NEW_MAP, r_found && !r_used[r_nb])
    `ASSERT_IMPL(a_erase_mapped, i_clk, i_rst_n, i_ctl.op == OP_ERASE, r_mapped)
    `ASSERT_IMPL(a_err_code, i_clk, i_rst_n, i_ctl.op == OP_EMIT_ERR,
        i_ctl.err == ST_UNMAPPED || i_ctl.err == ST_NO_FREE)
endmodule

>>> rtl/core/bmft_ctrl.sv
// controller state machine for the translation core
`include "assert_macros.svh"
module bmft_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_req_type,
    input  bmft_pkg::t_sts i_sts,
    output logic           o_load,
    output logic           o_busy,
    output bmft_pkg::t_ctl o_ctl
);
    import bmft_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_RD0    = 10'b0000000100,
        S_LOOK   = 10'b0000001000,
        S_SCAN0  = 10'b0000010000,
        S_SCAN   = 10'b0000100000,
        S_DECIDE = 10'b0001000000,
        S_MOVE   = 10'b0010000000,
        S_ERASE  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_wr, r_rd_half, n_rd_half, r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_wr      <= 1'b0;
            r_rd_half <= 1'b0;
            r_first   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_half <= n_rd_half;
            r_first   <= n_first;
            if (o_load) r_wr <= i_req_type;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_rd_half = r_rd_half;
        n_first   = 1'b0;
        o_load    = 1'b0;
        o_ctl     = '{op: OP_NONE, err: ST_OK, rd_half: r_rd_half, first: r_first};
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.op = OP_CLEAR;
                if (i_sts.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_load  = 1'b1;
                    n_state = S_RD0;
                end
            end
            S_RD0: n_state = S_LOOK;
            S_LOOK: begin
                o_ctl.op = OP_LOOKUP;
                n_state  = S_SCAN0;
            end
            S_SCAN0: begin
                if (!r_wr) begin
                    o_ctl.op = i_sts.mapped ? OP_EMIT_READ : OP_EMIT_ERR;
                    o_ctl.err = ST_UNMAPPED;
                    n_state  = S_DONE;
                end else begin
                    o_ctl.op    = OP_SCAN;
                    o_ctl.first = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.op = OP_SCAN;
                if (i_sts.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_sts.mapped) begin
                    o_ctl.op  = i_sts.have_free ? OP_NEW_MAP : OP_EMIT_ERR;
                    o_ctl.err = ST_NO_FREE;
                    n_state   = S_DONE;
                end else if (!i_sts.page_wr) begin
                    o_ctl.op = OP_DIRECT;
                    n_state  = S_DONE;
                end else if (!i_sts.have_free) begin
                    o_ctl.op  = OP_EMIT_ERR;
                    o_ctl.err = ST_NO_FREE;
                    n_state   = S_DONE;
                end else begin
                    o_ctl.op      = OP_MOVE;
                    o_ctl.first   = 1'b1;
                    o_ctl.rd_half = 1'b1;
                    n_rd_half     = 1'b1;
                    n_state       = S_MOVE;
                end
            end
            S_MOVE: begin
                o_ctl.op = OP_MOVE;
                o_ctl.first = 1'b0;
                if (r_rd_half && !i_sts.at_off) begin
                    n_rd_half = 1'b0;
                end else begin
                    // program half; the request page takes host data with no copy read
                    o_ctl.rd_half = 1'b0;
                    n_rd_half     = 1'b1;
                    if (i_sts.move_last) begin
                        n_state = S_ERASE;
                        n_first = 1'b1;
                    end
                end
            end
            S_ERASE: begin
                o_ctl.op = OP_ERASE;
                if (i_sts.move_last && !r_first) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        o_busy = (r_state != S_IDLE);
    end

    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, o_load, o_busy)
    `ASSERT_IMPL(a_load_idle, i_clk, i_rst_n, o_load, r_state == S_IDLE)
    `ASSERT_IMPL(a_state_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
endmodule

>>> rtl/core/block_mapped_flash_translation_core.sv
// top level: block-mapped flash translation core
// channel  | direction | handshake             | fields
// request  | in        | start, busy           | i_req_type, i_logical_page
// result   | out       | o_valid strobe        | o_command, o_flash_page, o_from_host,
//          |           |                       | o_status, o_last
// a read passes through RD0, LOOK, SCAN0 and DONE with busy high, its result valid in DONE
// a write adds a free-block scan (SCAN0, SCAN) and a decision state (DECIDE)
// an overwrite then emits 2*PAGES_PER_BLOCK-1 copy commands at one per cycle,
// and an erase phase emits the erase and clears old page bits
// after reset a clearing pass over every page of every block runs, busy high
// the result strobe cannot be held off
module block_mapped_flash_translation_core #(
    parameter int unsigned BLOCKS          = bmft_pkg::BLOCKS_DEF,
    parameter int unsigned PAGES_PER_BLOCK = bmft_pkg::PPB_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic [bmft_pkg::LP_W-1:0] i_logical_page,
    output logic                      o_valid,
    output logic [1:0]                o_command,
    output logic [bmft_pkg::LP_W-1:0] o_flash_page,
    output logic                      o_from_host,
    output logic [1:0]                o_status,
    output logic                      o_last
);
    import bmft_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_load;

    bmft_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req_type(i_req_type),
        .i_sts(w_sts), .o_load(w_load), .o_busy(busy), .o_ctl(w_ctl)
    );

    bmft_datapath #(.BLOCKS(BLOCKS), .PPB(PAGES_PER_BLOCK)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_load),
        .i_logical_page(i_logical_page), .i_ctl(w_ctl), .o_sts(w_sts),
        .o_valid(o_valid), .o_command(o_command), .o_flash_page(o_flash_page),
        .o_from_host(o_from_host), .o_status(o_status), .o_last(o_last)
    );
endmodule
